@@ src/segment_receive_tracker_top_defines.svh @@
`ifndef SEGMENT_RECEIVE_TRACKER_TOP_DEFINES_SVH
`define SEGMENT_RECEIVE_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/srt_pkg.sv @@
package srt_pkg;

    localparam int FILE_W         = 10;
    localparam int SEG_W          = 6;
    localparam int TOTAL_W        = 7;
    localparam int CHECK_W        = 64;
    localparam int BYTE_W         = 8;
    localparam int BYTES_PER_WORD = 8;
    localparam int POS_W          = $clog2(BYTES_PER_WORD);

    localparam int NUM_FILE_SLOTS = 1024;
    localparam int SEGS_PER_FILE  = 64;
    localparam int FILE_ADDR_W    = $clog2(NUM_FILE_SLOTS);

    localparam logic [TOTAL_W-1:0] COUNT_MAX = 7'd127;

    localparam int OUT_DEPTH = 3;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [FILE_W-1:0]  file_id;
        logic [SEG_W-1:0]   seg_index;
        logic [TOTAL_W-1:0] seg_total;
        logic [CHECK_W-1:0] sent_checksum;
        logic [BYTE_W-1:0]  data_byte;
        logic               last;
    } t_seg_in;

    typedef struct packed {
        logic [FILE_W-1:0]  ack_file;
        logic [SEG_W-1:0]   ack_segment;
        logic [CHECK_W-1:0] ack_check;
        logic               is_new;
        logic               file_complete;
    } t_ack_out;

    typedef struct packed {
        logic                     done;
        logic [TOTAL_W-1:0]       count;
        logic [SEGS_PER_FILE-1:0] bits;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    // file and segment numbers as little-endian 32-bit words, packed big-endian
    function automatic logic [CHECK_W-1:0] ack_checksum(
        input logic [FILE_W-1:0] file,
        input logic [SEG_W-1:0]  seg
    );
        logic [31:0] file_w;
        logic [31:0] seg_w;
        file_w = 32'(file);
        seg_w  = 32'(seg);
        return {file_w[7:0], file_w[15:8], file_w[23:16], file_w[31:24],
                seg_w[7:0], seg_w[15:8], seg_w[23:16], seg_w[31:24]};
    endfunction

endpackage

@@ src/srt_ram.sv @@
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/segment_receive_tracker_top.sv @@
// Channel   Direction  Handshake           Payload
// -------   ---------  ------------------  ---------------------
// input     in         i_valid / o_stall   i_data  (t_seg_in)
// output    out        o_valid / i_stall   o_data  (t_ack_out)
//
// One byte transaction per cycle while o_stall is low. A segment's last byte is
// registered into stage s1 as its tracking row is read; the row update and the queue
// write that raises o_valid follow. After reset a clearing pass writes the 1024
// tracking rows, one per cycle, with o_stall high until it is done. A 3-entry output
// queue absorbs i_stall; o_stall also rises when the queue and s1 could overflow.
module segment_receive_tracker_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  srt_pkg::t_seg_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output srt_pkg::t_ack_out o_data
);
    import srt_pkg::*;

    logic               in_acc;
    logic [CHECK_W-1:0] word_full;
    logic [POS_W-1:0]   pos_inc;
    logic [CHECK_W-1:0] xor_fold;
    logic [5:0]         pad_shamt;
    logic [CHECK_W-1:0] pad_word;
    logic               sum_match;

    logic [CHECK_W-1:0] r_xor;
    logic [CHECK_W-1:0] r_word;
    logic [POS_W-1:0]   r_pos;

    logic               r_s1_valid;
    logic [FILE_W-1:0]  r_s1_file;
    logic [SEG_W-1:0]   r_s1_seg;
    logic [TOTAL_W-1:0] r_s1_total;

    t_row               rd_row;
    t_row               cur_row;
    t_row               upd_row;
    logic               seg_seen;
    logic [TOTAL_W-1:0] new_count;
    logic               completes;
    logic               item_wr;
    logic               ram_wr_en;
    logic [FILE_ADDR_W-1:0] ram_wr_addr;
    t_row               ram_wr_data;

    logic                   r_fwd_valid;
    logic [FILE_W-1:0]      r_fwd_file;
    t_row                   r_fwd_row;

    logic                   r_clr_busy;
    logic [FILE_ADDR_W-1:0] r_clr_addr;

    t_ack_out           s1_ack;
    t_ack_out           r_q [OUT_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               q_pop;
    logic [CNT_W:0]     inflight;

    // checksum accumulation
    assign in_acc    = i_valid && !o_stall;
    assign word_full = {r_word[CHECK_W-BYTE_W-1:0], i_data.data_byte};
    assign pos_inc   = r_pos + POS_W'(1);
    assign xor_fold  = (pos_inc == '0) ? (r_xor ^ word_full) : r_xor;
    assign pad_shamt = {POS_W'(0) - pos_inc, 3'b000};
    assign pad_word  = (pos_inc == '0) ? '0 : (word_full << pad_shamt);
    assign sum_match = ((xor_fold ^ pad_word) == i_data.sent_checksum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor  <= '0;
            r_word <= '0;
            r_pos  <= '0;
        end else if (in_acc) begin
            if (i_data.last) begin
                r_xor  <= '0;
                r_word <= '0;
                r_pos  <= '0;
            end else begin
                r_xor  <= xor_fold;
                r_word <= (pos_inc == '0) ? '0 : word_full;
                r_pos  <= pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc && i_data.last && sum_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_file  <= i_data.file_id;
        r_s1_seg   <= i_data.seg_index;
        r_s1_total <= i_data.seg_total;
    end

    // per-file tracking row
    srt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_FILE_SLOTS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (FILE_ADDR_W'(i_data.file_id)),
        .o_rd_data (rd_row)
    );

    // a write at the read edge is not seen by the RAM read: take the written row
    assign cur_row   = (r_fwd_valid && (r_fwd_file == r_s1_file)) ? r_fwd_row : rd_row;
    assign seg_seen  = cur_row.bits[r_s1_seg];
    assign new_count = (cur_row.count < COUNT_MAX) ? (cur_row.count + TOTAL_W'(1))
                                                   : cur_row.count;
    assign completes = !cur_row.done && (new_count == r_s1_total);

    always_comb begin
        upd_row       = cur_row;
        upd_row.bits  = cur_row.bits | (SEGS_PER_FILE'(1) << r_s1_seg);
        upd_row.count = new_count;
        upd_row.done  = cur_row.done || completes;
    end

    assign item_wr     = r_s1_valid && !seg_seen;
    assign ram_wr_en   = r_clr_busy || item_wr;
    assign ram_wr_addr = r_clr_busy ? r_clr_addr : FILE_ADDR_W'(r_s1_file);
    assign ram_wr_data = r_clr_busy ? '0 : upd_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= item_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_file <= r_s1_file;
        r_fwd_row  <= upd_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + FILE_ADDR_W'(1);
            if (r_clr_addr == FILE_ADDR_W'(NUM_FILE_SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // result queue
    assign s1_ack.ack_file      = r_s1_file;
    assign s1_ack.ack_segment   = r_s1_seg;
    assign s1_ack.ack_check     = ack_checksum(r_s1_file, r_s1_seg);
    assign s1_ack.is_new        = !seg_seen;
    assign s1_ack.file_complete = !seg_seen && completes;

    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_rd_ptr];
    assign q_pop   = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (r_s1_valid && !q_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!r_s1_valid && q_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (r_s1_valid) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (q_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_q[r_wr_ptr] <= s1_ack;
        end
    end

    assign inflight = {1'b0, r_count} + (CNT_W + 1)'(r_s1_valid);
    assign o_stall  = r_clr_busy || (inflight >= (CNT_W + 1)'(OUT_DEPTH));

endmodule

@@ src/srt_checker.sv @@
`include "segment_receive_tracker_top_defines.svh"

module srt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input srt_pkg::t_seg_in  i_data,
    input logic              o_valid,
    input logic              i_stall,
    input srt_pkg::t_ack_out o_data
);
    import srt_pkg::*;

    `SRT_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data), "stalled ack changed")
    `SRT_ASSERT_NOW(a_ack_latency, $rose(o_valid), $past(i_valid && !o_stall && i_data.last, 2), "ack without a last byte two cycles before")
    `SRT_ASSERT_NOW(a_complete_new, o_valid && o_data.file_complete, o_data.is_new, "file complete on a duplicate segment")
    `SRT_ASSERT_NOW(a_clear_stall, $past(!i_rst_n), o_stall, "input taken during clearing pass")

endmodule

bind segment_receive_tracker_top srt_checker u_srt_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import srt_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 1270;
    localparam int SWEEP_FILE  = 512;

    typedef enum logic [1:0] {ACK_PREDICTED, ACK_TYPED, ACK_NONE} t_ack_src;

    typedef struct {
        t_seg_in  item;
        t_ack_src src;
        t_ack_out ack;
    } t_byte_entry;

    typedef struct {
        int          file;
        int          seg;
        int          total;
        int          nbytes;
        int          fill;
        bit          corrupt;
        t_ack_src    src;
        logic        is_new;
        logic        complete;
        logic [63:0] check;
    } t_seg_row;

    // fill < 0 means random payload bytes, otherwise byte i is fill + i
    t_seg_row directed_segs [8] = '{
        '{0,    0,  1,   1, 8'h00, 1'b0, ACK_TYPED,     1'b1, 1'b1, 64'h0},
        '{0,    0,  1,   1, 8'h00, 1'b0, ACK_TYPED,     1'b0, 1'b0, 64'h0},
        '{1023, 63, 64,  1, 8'hff, 1'b0, ACK_TYPED,     1'b1, 1'b0, 64'hff0300003f000000},
        '{1023, 63, 64,  1, 8'hff, 1'b1, ACK_NONE,      1'b0, 1'b0, 64'h0},
        '{5,    1,  0,   8, 8'h80, 1'b0, ACK_PREDICTED, 1'b0, 1'b0, 64'h0},
        '{5,    2,  2,   9, 8'h7f, 1'b0, ACK_TYPED,     1'b1, 1'b1, 64'h0500000002000000},
        '{5,    3,  3,   1, 8'h01, 1'b0, ACK_TYPED,     1'b1, 1'b0, 64'h0500000003000000},
        '{7,    0,  127, 1, 8'haa, 1'b0, ACK_PREDICTED, 1'b0, 1'b0, 64'h0}
    };

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_seg_in  i_data  = '0;
    logic     i_stall = 1'b0;
    logic     o_stall;
    logic     o_valid;
    t_ack_out o_data;

    segment_receive_tracker_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [63:0]        seg_xor  = '0;
    logic [63:0]        word_acc = '0;
    logic [2:0]         byte_cnt = '0;
    logic [63:0]        seen_rows    [NUM_FILE_SLOTS] = '{default: '0};
    logic [TOTAL_W-1:0] seg_cnt      [NUM_FILE_SLOTS] = '{default: '0};
    logic               file_flagged [NUM_FILE_SLOTS] = '{default: 1'b0};

    t_byte_entry byte_q[$];
    t_ack_out    pending_acks[$];
    t_byte_entry cur;
    logic        have_cur = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    logic        rx_hold = 1'b0;
    logic        quiet_tx = 1'b0;
    logic        quiet_rx = 1'b0;
    int          cycles = 0;
    int          items_queued = 0;
    int          items_taken = 0;
    int          segs_queued = 0;
    int          acks_checked = 0;
    int          new_seen = 0;
    int          done_seen = 0;
    int          errors = 0;
    event        hold_evt;

    function automatic logic track_byte(input t_seg_in it, output t_ack_out ack);
        logic [63:0] sum;
        ack = '0;
        word_acc = {word_acc[55:0], it.data_byte};
        byte_cnt = byte_cnt + 3'd1;
        if (byte_cnt == 3'd0) begin
            seg_xor  = seg_xor ^ word_acc;
            word_acc = '0;
        end
        if (!it.last)
            return 1'b0;
        if (byte_cnt != 3'd0)
            word_acc = word_acc << (8 * (8 - int'(byte_cnt)));
        sum      = seg_xor ^ word_acc;
        seg_xor  = '0;
        word_acc = '0;
        byte_cnt = '0;
        if (sum != it.sent_checksum)
            return 1'b0;
        ack.ack_file    = it.file_id;
        ack.ack_segment = it.seg_index;
        ack.ack_check   = {it.file_id[7:0], 6'b0, it.file_id[9:8], 16'b0,
                           2'b0, it.seg_index, 24'b0};
        if (int'(it.file_id) < NUM_FILE_SLOTS && int'(it.seg_index) < SEGS_PER_FILE
                && !seen_rows[it.file_id][it.seg_index]) begin
            seen_rows[it.file_id][it.seg_index] = 1'b1;
            ack.is_new = 1'b1;
            if (seg_cnt[it.file_id] < COUNT_MAX)
                seg_cnt[it.file_id] = seg_cnt[it.file_id] + TOTAL_W'(1);
            if (!file_flagged[it.file_id] && seg_cnt[it.file_id] == it.seg_total) begin
                file_flagged[it.file_id] = 1'b1;
                ack.file_complete = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // header fields on non-final bytes are random noise
    task automatic queue_segment(input int file, input int seg, input int total,
                                 input int nbytes, input int fill, input bit corrupt,
                                 input t_ack_src src, input t_ack_out ack);
        logic [63:0] sum;
        logic [7:0]  b;
        t_byte_entry e;
        sum = '0;
        for (int i = 0; i < nbytes; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill + i);
            sum = sum ^ ({56'b0, b} << (8 * (7 - (i % 8))));
            e.item.file_id       = 10'($urandom);
            e.item.seg_index     = 6'($urandom);
            e.item.seg_total     = 7'($urandom);
            e.item.sent_checksum = {$urandom, $urandom};
            e.item.data_byte     = b;
            e.item.last          = 1'b0;
            e.src = ACK_PREDICTED;
            e.ack = '0;
            if (i == nbytes - 1) begin
                e.item.file_id       = 10'(file);
                e.item.seg_index     = 6'(seg);
                e.item.seg_total     = 7'(total);
                e.item.sent_checksum = corrupt ? sum ^ (64'd1 << $urandom_range(0, 63)) : sum;
                e.item.last          = 1'b1;
                e.src = src;
                e.ack = ack;
            end
            byte_q.push_back(e);
            items_queued++;
        end
        segs_queued++;
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || pending_acks.size() != 0)
            @(posedge i_clk);
    endtask

    // input side
    always @(posedge i_clk) begin
        t_ack_out pred;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                if (track_byte(cur.item, pred) && cur.src == ACK_PREDICTED)
                    pending_acks.push_back(pred);
                if (cur.src == ACK_TYPED)
                    pending_acks.push_back(cur.ack);
                items_taken++;
                have_cur = 1'b0;
            end
            if (!(i_valid && o_stall)) begin
                if (!have_cur && byte_q.size() != 0) begin
                    cur      = byte_q.pop_front();
                    have_cur = 1'b1;
                    gap_left = quiet_tx ? 0 : $urandom_range(0, 8);
                end
                if (have_cur && gap_left == 0) begin
                    i_valid <= 1'b1;
                    i_data  <= cur.item;
                end else begin
                    i_valid <= 1'b0;
                    if (have_cur)
                        gap_left--;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_ack_out want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                acks_checked++;
                new_seen  += o_data.is_new;
                done_seen += o_data.file_complete;
                if (pending_acks.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display({"unexpected ack: exp none, got file %0d seg %0d ",
                                  "check %h new %b done %b"},
                                 o_data.ack_file, o_data.ack_segment, o_data.ack_check,
                                 o_data.is_new, o_data.file_complete);
                end else begin
                    want = pending_acks.pop_front();
                    if (o_data.ack_file !== want.ack_file
                            || o_data.ack_segment !== want.ack_segment
                            || o_data.ack_check !== want.ack_check
                            || o_data.is_new !== want.is_new
                            || o_data.file_complete !== want.file_complete) begin
                        errors++;
                        if (errors <= 10)
                            $display({"ack mismatch: exp file %0d seg %0d check %h ",
                                      "new %b done %b, got file %0d seg %0d check %h ",
                                      "new %b done %b"},
                                     want.ack_file, want.ack_segment, want.ack_check,
                                     want.is_new, want.file_complete,
                                     o_data.ack_file, o_data.ack_segment, o_data.ack_check,
                                     o_data.is_new, o_data.file_complete);
                    end
                end
                stall_left = quiet_rx ? 0 : $urandom_range(0, 8);
            end
            i_stall <= rx_hold || stall_left > 0;
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial begin
        forever begin
            @(hold_evt);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles % 150 == 0) begin
            quiet_tx <= ($urandom_range(0, 3) == 0);
            quiet_rx <= ($urandom_range(0, 3) == 0);
        end
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void renew_pool(ref int pf[8], ref int pt[8], input int k);
        pf[k] = $urandom_range(0, 1023);
        pt[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6);
    endfunction

    initial begin
        t_seg_row row;
        t_ack_out ack;
        int       pool_file [8];
        int       pool_total [8];
        int       order [64];
        int       k;
        int       nb;
        int       hi;
        int       pick;
        int       j;
        int       t;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_segs[r]) begin
            row = directed_segs[r];
            ack.ack_file      = 10'(row.file);
            ack.ack_segment   = 6'(row.seg);
            ack.ack_check     = row.check;
            ack.is_new        = row.is_new;
            ack.file_complete = row.complete;
            queue_segment(row.file, row.seg, row.total, row.nbytes, row.fill,
                          row.corrupt, row.src, ack);
        end
        wait_drained();

        // receiver holds off while one-byte segments keep arriving
        -> hold_evt;
        for (int i = 0; i < 48; i++)
            queue_segment($urandom_range(0, 1023), $urandom_range(0, 63),
                          $urandom_range(0, 127), 1, -1, 1'b0, ACK_PREDICTED, '0);
        wait_drained();

        for (int i = 0; i < 8; i++)
            renew_pool(pool_file, pool_total, i);
        while (items_queued < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            nb = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            if (pick < 70) begin
                k  = $urandom_range(0, 7);
                hi = (pool_total[k] + 1 > 63) ? 63 : pool_total[k] + 1;
                queue_segment(pool_file[k], $urandom_range(0, hi), pool_total[k], nb, -1,
                              ($urandom_range(0, 6) == 0), ACK_PREDICTED, '0);
                if ($urandom_range(0, 11) == 0)
                    renew_pool(pool_file, pool_total, $urandom_range(0, 7));
            end else begin
                queue_segment($urandom_range(0, 1023), $urandom_range(0, 63),
                              $urandom_range(0, 127), nb, -1, (pick >= 85),
                              ACK_PREDICTED, '0);
            end
        end

        // one file filled to its full 64 segments, in shuffled order
        for (int i = 0; i < 64; i++)
            order[i] = i;
        for (int i = 63; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < 64; i++)
            queue_segment(SWEEP_FILE, order[i], 64, $urandom_range(1, 3), -1, 1'b0,
                          ACK_PREDICTED, '0);
        queue_segment(SWEEP_FILE, order[0], 64, 2, -1, 1'b0, ACK_PREDICTED, '0);

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("covered %0d byte transactions in %0d segments; %0d acks checked",
                 items_taken, segs_queued, acks_checked);
        $display("%0d first arrivals, %0d file completions, %0d mismatches",
                 new_seen, done_seen, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/srt_pkg.sv
src/srt_ram.sv
src/segment_receive_tracker_top.sv
src/srt_checker.sv
test/tb.sv
